### src/mtep_pkg.sv
// Shared types, codes and status decode for the MIDI track event parser.
// No dependencies.
package mtep_pkg;

    localparam int VLQ_MAX_BYTES_DEF = 4;

    localparam int TIME_W = 28;
    localparam int BYTE_W = 8;

    // result kinds
    localparam logic [2:0] KIND_CHANNEL    = 3'd0;
    localparam logic [2:0] KIND_SYSEX_HDR  = 3'd1;
    localparam logic [2:0] KIND_META_HDR   = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD    = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_VLQ_LONG   = 2'd1;
    localparam logic [1:0] ERR_BAD_STATUS = 2'd2;

    // special status and meta bytes
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;

    // status classes
    localparam logic [2:0] CLS_TWO   = 3'd0;
    localparam logic [2:0] CLS_ONE   = 3'd1;
    localparam logic [2:0] CLS_SYSEX = 3'd2;
    localparam logic [2:0] CLS_META  = 3'd3;
    localparam logic [2:0] CLS_BAD   = 3'd4;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [TIME_W-1:0] event_ticks;
        logic [BYTE_W-1:0] event_code;
        logic [3:0]        channel;
        logic [BYTE_W-1:0] param_first;
        logic [BYTE_W-1:0] param_second;
        logic [BYTE_W-1:0] meta_type;
        logic [TIME_W-1:0] payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_event;
        logic              end_of_track;
        logic [1:0]        error_code;
    } result_t;

    function automatic logic [2:0] status_class(input logic [7:0] st);
        logic [2:0] cls;
        unique case (st) inside
            [8'h80:8'hBF], [8'hE0:8'hEF]: cls = CLS_TWO;
            [8'hC0:8'hDF]:                cls = CLS_ONE;
            ST_SYSEX, ST_SYSEX_ESC:       cls = CLS_SYSEX;
            ST_META:                      cls = CLS_META;
            default:                      cls = CLS_BAD;
        endcase
        return cls;
    endfunction

endpackage

### src/midi_track_event_parser.sv
// MIDI track event parser: one track byte in, at most one result out per item.
// Depends on mtep_pkg.
//
// Usage:
//   s_valid/s_ready/s_stream_byte carry the raw track bytes that follow the
//   MTrk chunk header, one byte per item. m_valid/m_ready carry the results:
//   channel events, sysex/meta headers, payload bytes and errors.
//   An accepted byte lands in an input register and is parsed from there
//   into the result register, which presents its result on m_valid/m_ready.
//   One byte per cycle is sustained as long as the receiver keeps m_ready
//   high; the rate is set by the single parse step between the input and
//   result registers.
//   While a result waits for m_ready, one more byte is taken into the input
//   register; bytes that cause no result keep flowing through. A byte that
//   would produce a result waits in the input register until the result
//   register frees up, which then backpressures s_ready.
//   After an error result (over-long length value or unknown status) the
//   block drops every byte without results until aresetn is asserted.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to expecting a delta time with no running status.
module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_result_kind,
    output logic [TIME_W-1:0] m_event_ticks,
    output logic [7:0]        m_event_code,
    output logic [3:0]        m_channel,
    output logic [7:0]        m_param_first,
    output logic [7:0]        m_param_second,
    output logic [7:0]        m_meta_type,
    output logic [TIME_W-1:0] m_payload_length,
    output logic [7:0]        m_payload_byte,
    output logic              m_last_of_event,
    output logic              m_end_of_track,
    output logic [1:0]        m_error_code
);

    localparam int CNT_W = $clog2(VLQ_MAX_BYTES + 1);

    localparam logic [2:0] PH_DELTA    = 3'd0;
    localparam logic [2:0] PH_STATUS   = 3'd1;
    localparam logic [2:0] PH_PARAM1   = 3'd2;
    localparam logic [2:0] PH_PARAM2   = 3'd3;
    localparam logic [2:0] PH_METATYPE = 3'd4;
    localparam logic [2:0] PH_LENGTH   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              m_valid_reg;
    result_t           result_reg;

    logic [2:0]        phase_reg,      phase_next;
    logic [TIME_W-1:0] delta_reg,      delta_next;
    logic [CNT_W-1:0]  vlq_cnt_reg,    vlq_cnt_next;
    logic [7:0]        status_reg,     status_next;
    logic [7:0]        held_param_reg, held_param_next;
    logic [7:0]        held_meta_reg,  held_meta_next;
    logic [TIME_W-1:0] length_reg,     length_next;
    logic [TIME_W-1:0] bytes_left_reg, bytes_left_next;
    logic              halted_reg,     halted_next;

    result_t           res;
    logic              emit;
    logic              proc;
    logic              out_free;
    logic [7:0]        b;
    logic [7:0]        eff_status;
    logic [2:0]        cls;
    logic [TIME_W-1:0] vlq_src;
    logic [TIME_W-1:0] vlq_shift;
    logic [CNT_W-1:0]  cnt_inc;
    logic              too_long;
    logic              is_meta;
    logic              eot;
    logic              do_err;
    logic [1:0]        err_code;
    logic              do_chan;
    logic [7:0]        chan_p1;
    logic [7:0]        chan_p2;
    logic              do_len;
    logic              do_done;

    always_comb begin
        b          = in_byte_reg;
        eff_status = (phase_reg == PH_STATUS && b[7]) ? b : status_reg;
        cls        = status_class(eff_status);
        vlq_src    = (phase_reg == PH_DELTA) ? delta_reg : length_reg;
        vlq_shift  = {vlq_src[TIME_W-8:0], b[6:0]};
        cnt_inc    = vlq_cnt_reg + CNT_W'(1);
        too_long   = b[7] && (cnt_inc >= CNT_W'(VLQ_MAX_BYTES));
        is_meta    = eff_status == ST_META;
        eot        = is_meta && held_meta_reg == META_EOT;

        phase_next      = phase_reg;
        delta_next      = delta_reg;
        vlq_cnt_next    = vlq_cnt_reg;
        status_next     = status_reg;
        held_param_next = held_param_reg;
        held_meta_next  = held_meta_reg;
        length_next     = length_reg;
        bytes_left_next = bytes_left_reg;
        halted_next     = halted_reg;

        res      = '0;
        emit     = 1'b0;
        do_err   = 1'b0;
        err_code = ERR_NONE;
        do_chan  = 1'b0;
        chan_p1  = b;
        chan_p2  = '0;
        do_len   = 1'b0;
        do_done  = 1'b0;

        if (!halted_reg) begin
            unique case (phase_reg)
                PH_DELTA: begin
                    delta_next = vlq_shift;
                    if (!b[7]) begin
                        vlq_cnt_next = '0;
                        phase_next   = PH_STATUS;
                    end else if (too_long) begin
                        do_err   = 1'b1;
                        err_code = ERR_VLQ_LONG;
                    end else begin
                        vlq_cnt_next = cnt_inc;
                    end
                end
                PH_STATUS: begin
                    status_next = eff_status;
                    if (b[7]) begin
                        unique case (cls)
                            CLS_TWO, CLS_ONE: phase_next = PH_PARAM1;
                            CLS_SYSEX: begin
                                held_meta_next = '0;
                                length_next    = '0;
                                vlq_cnt_next   = '0;
                                phase_next     = PH_LENGTH;
                            end
                            CLS_META: phase_next = PH_METATYPE;
                            default: begin
                                do_err   = 1'b1;
                                err_code = ERR_BAD_STATUS;
                            end
                        endcase
                    end else begin
                        // running status: this byte is the first after the status
                        unique case (cls)
                            CLS_TWO: begin
                                held_param_next = b;
                                phase_next      = PH_PARAM2;
                            end
                            CLS_ONE: do_chan = 1'b1;
                            CLS_SYSEX: begin
                                held_meta_next = '0;
                                do_len         = 1'b1;
                            end
                            CLS_META: begin
                                held_meta_next = b;
                                length_next    = '0;
                                vlq_cnt_next   = '0;
                                phase_next     = PH_LENGTH;
                            end
                            default: begin
                                do_err   = 1'b1;
                                err_code = ERR_BAD_STATUS;
                            end
                        endcase
                    end
                end
                PH_PARAM1: begin
                    if (cls == CLS_ONE) begin
                        do_chan = 1'b1;
                    end else begin
                        held_param_next = b;
                        phase_next      = PH_PARAM2;
                    end
                end
                PH_PARAM2: begin
                    do_chan = 1'b1;
                    chan_p1 = held_param_reg;
                    chan_p2 = b;
                end
                PH_METATYPE: begin
                    held_meta_next = b;
                    length_next    = '0;
                    vlq_cnt_next   = '0;
                    phase_next     = PH_LENGTH;
                end
                PH_LENGTH: do_len = 1'b1;
                PH_PAYLOAD: begin
                    emit                = 1'b1;
                    res.result_kind     = KIND_PAYLOAD;
                    res.event_ticks     = delta_reg;
                    res.event_code      = eff_status;
                    res.meta_type       = is_meta ? held_meta_reg : '0;
                    res.payload_length  = length_reg;
                    res.payload_byte    = b;
                    res.end_of_track    = eot;
                    bytes_left_next     = bytes_left_reg - TIME_W'(1);
                    if (bytes_left_next == '0) begin
                        res.last_of_event = 1'b1;
                        do_done           = 1'b1;
                    end
                end
                default: phase_next = PH_DELTA;
            endcase
        end

        if (do_len) begin
            length_next = vlq_shift;
            phase_next  = PH_LENGTH;
            if (b[7]) begin
                if (too_long) begin
                    do_err   = 1'b1;
                    err_code = ERR_VLQ_LONG;
                end else begin
                    vlq_cnt_next = cnt_inc;
                end
            end else begin
                vlq_cnt_next       = '0;
                emit               = 1'b1;
                res.result_kind    = is_meta ? KIND_META_HDR : KIND_SYSEX_HDR;
                res.event_ticks    = delta_reg;
                res.event_code     = eff_status;
                res.meta_type      = is_meta ? held_meta_reg : '0;
                res.payload_length = vlq_shift;
                res.end_of_track   = eot;
                if (vlq_shift == '0) begin
                    res.last_of_event = 1'b1;
                    do_done           = 1'b1;
                end else begin
                    bytes_left_next = vlq_shift;
                    phase_next      = PH_PAYLOAD;
                end
            end
        end

        if (do_chan) begin
            emit              = 1'b1;
            res.result_kind   = KIND_CHANNEL;
            res.event_ticks   = delta_reg;
            res.event_code    = {eff_status[7:4], 4'h0};
            res.channel       = eff_status[3:0];
            res.param_first   = chan_p1;
            res.param_second  = chan_p2;
            res.last_of_event = 1'b1;
            do_done           = 1'b1;
        end

        if (do_done) begin
            phase_next      = PH_DELTA;
            delta_next      = '0;
            vlq_cnt_next    = '0;
            length_next     = '0;
            bytes_left_next = '0;
            held_param_next = '0;
            if (eot) begin
                status_next = '0;
            end
        end

        if (do_err) begin
            emit            = 1'b1;
            res             = '0;
            res.result_kind = KIND_ERROR;
            res.error_code  = err_code;
            halted_next     = 1'b1;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign proc     = in_valid_reg && (out_free || !emit);
    assign s_ready  = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            phase_reg      <= PH_DELTA;
            delta_reg      <= '0;
            vlq_cnt_reg    <= '0;
            status_reg     <= '0;
            length_reg     <= '0;
            bytes_left_reg <= '0;
            halted_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (proc) begin
                phase_reg      <= phase_next;
                delta_reg      <= delta_next;
                vlq_cnt_reg    <= vlq_cnt_next;
                status_reg     <= status_next;
                length_reg     <= length_next;
                bytes_left_reg <= bytes_left_next;
                halted_reg     <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_stream_byte;
        end
        if (proc) begin
            held_param_reg <= held_param_next;
            held_meta_reg  <= held_meta_next;
        end
        if (proc && emit) begin
            result_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = result_reg.result_kind;
    assign m_event_ticks    = result_reg.event_ticks;
    assign m_event_code     = result_reg.event_code;
    assign m_channel        = result_reg.channel;
    assign m_param_first    = result_reg.param_first;
    assign m_param_second   = result_reg.param_second;
    assign m_meta_type      = result_reg.meta_type;
    assign m_payload_length = result_reg.payload_length;
    assign m_payload_byte   = result_reg.payload_byte;
    assign m_last_of_event  = result_reg.last_of_event;
    assign m_end_of_track   = result_reg.end_of_track;
    assign m_error_code     = result_reg.error_code;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && proc) |-> !emit)
        else $error("result produced while halted");

    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_ERROR) |-> halted_reg)
        else $error("error item without halt");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");

endmodule

### tb/sv/tb_midi_track_event_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for midi_track_event_parser: random well-formed MIDI track
// streams with one halting error at the end, random stalls on both sides, checked
// result by result against an in-bench parser. Depends on mtep_pkg and the RTL.
module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1450;
    localparam int MAX_PRINTS   = 40;

    // channel message classes (high nibble of the status)
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_POLY_AT   = 8'hA0;
    localparam logic [7:0] ST_CONTROL   = 8'hB0;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT   = 8'hD0;
    localparam logic [7:0] ST_PITCH     = 8'hE0;
    localparam logic [7:0] ST_SYSTEM    = 8'hF0;

    typedef enum logic [2:0] {
        AWAIT_DELTA, AWAIT_STATUS, AWAIT_PARAM1, AWAIT_PARAM2,
        AWAIT_TYPE, AWAIT_LENGTH, AWAIT_PAYLOAD
    } parse_phase_e;

    typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_OVERLONG} vlq_e;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [7:0]        s_stream_byte  = 8'h00;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [2:0]        m_result_kind;
    logic [TIME_W-1:0] m_event_ticks;
    logic [7:0]        m_event_code;
    logic [3:0]        m_channel;
    logic [7:0]        m_param_first;
    logic [7:0]        m_param_second;
    logic [7:0]        m_meta_type;
    logic [TIME_W-1:0] m_payload_length;
    logic [7:0]        m_payload_byte;
    logic              m_last_of_event;
    logic              m_end_of_track;
    logic [1:0]        m_error_code;

    midi_track_event_parser u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stream_byte    (s_stream_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_event_ticks    (m_event_ticks),
        .m_event_code     (m_event_code),
        .m_channel        (m_channel),
        .m_param_first    (m_param_first),
        .m_param_second   (m_param_second),
        .m_meta_type      (m_meta_type),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_event  (m_last_of_event),
        .m_end_of_track   (m_end_of_track),
        .m_error_code     (m_error_code)
    );

    always #5 aclk = ~aclk;

    logic [7:0] track_bytes [$];
    result_t    awaited_results [$];
    int         fail_count   = 0;
    int         got_count    = 0;
    int         quiet_cycles = 0;

    // ---------------- parser state ----------------
    parse_phase_e      phase;
    logic [27:0]       delta_acc;
    logic [2:0]        vlq_bytes;
    logic [7:0]        run_status;
    logic [7:0]        cur_status;
    logic [7:0]        held_param;
    logic [7:0]        held_type;
    logic [27:0]       length_acc;
    logic [27:0]       bytes_left;
    logic              halted;

    task automatic clear_parser();
        phase      = AWAIT_DELTA;
        delta_acc  = '0;
        vlq_bytes  = '0;
        run_status = '0;
        cur_status = '0;
        held_param = '0;
        held_type  = '0;
        length_acc = '0;
        bytes_left = '0;
        halted     = 1'b0;
    endtask

    task automatic take_vlq_byte(input logic [7:0] b, inout logic [27:0] acc,
                                 output vlq_e res);
        acc       = {acc[20:0], b[6:0]};
        vlq_bytes = vlq_bytes + 3'd1;
        if (!b[7]) begin
            vlq_bytes = '0;
            res = VLQ_DONE;
        end else if (vlq_bytes >= VLQ_MAX_BYTES_DEF) begin
            res = VLQ_OVERLONG;
        end else begin
            res = VLQ_MORE;
        end
    endtask

    task automatic push_error(input logic [1:0] code);
        result_t r;
        r             = '0;
        r.result_kind = KIND_ERROR;
        r.error_code  = code;
        halted        = 1'b1;
        awaited_results.push_back(r);
    endtask

    task automatic end_event(input logic eot);
        phase      = AWAIT_DELTA;
        delta_acc  = '0;
        vlq_bytes  = '0;
        length_acc = '0;
        bytes_left = '0;
        held_param = '0;
        if (eot) begin
            run_status = '0;
            cur_status = '0;
        end
    endtask

    task automatic push_channel(input logic [7:0] p1, input logic [7:0] p2);
        result_t r;
        r               = '0;
        r.result_kind   = KIND_CHANNEL;
        r.event_ticks   = delta_acc;
        r.event_code    = cur_status & 8'hF0;
        r.channel       = cur_status[3:0];
        r.param_first   = p1;
        r.param_second  = p2;
        r.last_of_event = 1'b1;
        awaited_results.push_back(r);
        end_event(1'b0);
    endtask

    function automatic result_t block_result(input logic [2:0] kind);
        result_t r;
        r                = '0;
        r.result_kind    = kind;
        r.event_ticks    = delta_acc;
        r.event_code     = cur_status;
        r.payload_length = length_acc;
        if (cur_status == ST_META) begin
            r.meta_type    = held_type;
            r.end_of_track = (held_type == META_EOT);
        end
        return r;
    endfunction

    task automatic length_step(input logic [7:0] b);
        vlq_e    res;
        result_t r;
        take_vlq_byte(b, length_acc, res);
        if (res == VLQ_OVERLONG) begin
            push_error(ERR_VLQ_LONG);
        end else if (res == VLQ_DONE) begin
            r = block_result(cur_status == ST_META ? KIND_META_HDR : KIND_SYSEX_HDR);
            if (length_acc == '0) begin
                r.last_of_event = 1'b1;
                end_event(r.end_of_track);
            end else begin
                bytes_left = length_acc;
                phase      = AWAIT_PAYLOAD;
            end
            awaited_results.push_back(r);
        end
    endtask

    task automatic start_length(input logic [7:0] mtype);
        held_type  = mtype;
        length_acc = '0;
        vlq_bytes  = '0;
        phase      = AWAIT_LENGTH;
    endtask

    task automatic dispatch_status(input logic [7:0] b, input logic have_first);
        case (cur_status & 8'hF0)
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CONTROL, ST_PITCH: begin
                if (have_first) begin
                    held_param = b;
                    phase      = AWAIT_PARAM2;
                end else begin
                    phase = AWAIT_PARAM1;
                end
            end
            ST_PROGRAM, ST_CHAN_AT: begin
                if (have_first) push_channel(b, 8'h00);
                else phase = AWAIT_PARAM1;
            end
            default: begin
                if (cur_status == ST_SYSEX || cur_status == ST_SYSEX_ESC) begin
                    start_length(8'h00);
                end else if (cur_status == ST_META) begin
                    if (have_first) start_length(b);
                    else phase = AWAIT_TYPE;
                end else begin
                    push_error(ERR_BAD_STATUS);
                end
            end
        endcase
    endtask

    task automatic advance_parser(input logic [7:0] b);
        vlq_e    res;
        result_t r;
        if (halted) return;
        case (phase)
            AWAIT_STATUS: begin
                if (b[7]) begin
                    run_status = b;
                    cur_status = b;
                    dispatch_status(b, 1'b0);
                end else begin
                    cur_status = run_status;
                    if (cur_status == ST_SYSEX || cur_status == ST_SYSEX_ESC) begin
                        dispatch_status(b, 1'b0);
                        length_step(b);
                    end else begin
                        dispatch_status(b, 1'b1);
                    end
                end
            end
            AWAIT_PARAM1: begin
                if ((cur_status & 8'hF0) == ST_PROGRAM || (cur_status & 8'hF0) == ST_CHAN_AT)
                begin
                    push_channel(b, 8'h00);
                end else begin
                    held_param = b;
                    phase      = AWAIT_PARAM2;
                end
            end
            AWAIT_PARAM2: push_channel(held_param, b);
            AWAIT_TYPE:   start_length(b);
            AWAIT_LENGTH: length_step(b);
            AWAIT_PAYLOAD: begin
                r              = block_result(KIND_PAYLOAD);
                r.payload_byte = b;
                bytes_left     = bytes_left - 28'd1;
                if (bytes_left == '0) begin
                    r.last_of_event = 1'b1;
                    end_event(r.end_of_track);
                end
                awaited_results.push_back(r);
            end
            default: begin
                take_vlq_byte(b, delta_acc, res);
                if (res == VLQ_OVERLONG) push_error(ERR_VLQ_LONG);
                else if (res == VLQ_DONE) phase = AWAIT_STATUS;
            end
        endcase
    endtask

    // ---------------- stream generation ----------------
    logic [7:0] gen_run = 8'h00;

    task automatic put_vlq(input logic [27:0] value, input int pad);
        int groups;
        groups = 1;
        while (groups < 4 && (value >> (7 * groups)) != 0) groups++;
        if (pad > groups) groups = pad;
        for (int i = groups - 1; i >= 0; i--)
            track_bytes.push_back({i != 0, value[7*i +: 7]});
    endtask

    function automatic int vlq_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 1;
    endfunction

    function automatic logic [27:0] rand_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 28'd0;
            4, 5, 6:    return 28'($urandom_range(1, 127));
            7:          return 28'($urandom_range(128, 16383));
            8:          return 28'hFFFFFFF;
            default:    return 28'($urandom());
        endcase
    endfunction

    function automatic int rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 3);
        if (r < 90) return $urandom_range(4, 12);
        if (r < 98) return $urandom_range(13, 40);
        return $urandom_range(128, 200);
    endfunction

    function automatic logic [7:0] any_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] channel_class(input int k);
        case (k)
            0:       return ST_NOTE_OFF;
            1:       return ST_NOTE_ON;
            2:       return ST_POLY_AT;
            3:       return ST_CONTROL;
            4:       return ST_PROGRAM;
            5:       return ST_CHAN_AT;
            default: return ST_PITCH;
        endcase
    endfunction

    task automatic put_payload(input int len);
        repeat (len) track_bytes.push_back(any_byte());
    endtask

    task automatic gen_channel_event();
        logic [7:0] st;
        put_vlq(rand_delta(), vlq_pad());
        if (gen_run >= ST_NOTE_OFF && gen_run < ST_SYSTEM && $urandom_range(0, 2) == 0) begin
            st = gen_run;
            track_bytes.push_back(8'($urandom_range(0, 127)));
        end else begin
            st = channel_class($urandom_range(0, 6)) | 8'($urandom_range(0, 15));
            gen_run = st;
            track_bytes.push_back(st);
            track_bytes.push_back(any_byte());
        end
        if ((st & 8'hF0) != ST_PROGRAM && (st & 8'hF0) != ST_CHAN_AT)
            track_bytes.push_back(any_byte());
    endtask

    task automatic gen_sysex_event();
        int len;
        len = rand_length();
        put_vlq(rand_delta(), vlq_pad());
        if ((gen_run == ST_SYSEX || gen_run == ST_SYSEX_ESC) && len < 128
            && $urandom_range(0, 2) == 0) begin
            track_bytes.push_back(8'(len));
        end else begin
            gen_run = $urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC;
            track_bytes.push_back(gen_run);
            put_vlq(28'(len), vlq_pad());
        end
        put_payload(len);
    endtask

    task automatic gen_meta_event(input logic eot);
        int         len;
        logic [7:0] mtype;
        if (eot) begin
            mtype = META_EOT;
            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        end else begin
            do mtype = 8'($urandom_range(0, 255)); while (mtype == META_EOT);
            len = rand_length();
        end
        put_vlq(rand_delta(), vlq_pad());
        if (gen_run == ST_META && !mtype[7] && $urandom_range(0, 2) == 0) begin
            track_bytes.push_back(mtype);
        end else begin
            gen_run = ST_META;
            track_bytes.push_back(ST_META);
            track_bytes.push_back(mtype);
        end
        put_vlq(28'(len), vlq_pad());
        put_payload(len);
        if (eot) gen_run = 8'h00;
    endtask

    // one halting error to close the stream, then bytes that must be dropped
    task automatic append_halting_error();
        logic [7:0] bad;
        case ($urandom_range(0, 3))
            0: repeat (4) track_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            1: begin
                track_bytes.push_back(8'h00);
                track_bytes.push_back(ST_SYSEX);
                repeat (4) track_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            2: begin
                do bad = 8'($urandom_range(8'hF1, 8'hFE)); while (bad == ST_SYSEX_ESC);
                track_bytes.push_back(8'h00);
                track_bytes.push_back(bad);
            end
            default: begin
                gen_meta_event(1'b1);
                track_bytes.push_back(8'h00);
                track_bytes.push_back(8'($urandom_range(0, 127)));
            end
        endcase
        repeat (6) track_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // ---------------- idling ----------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 10);
        return $urandom_range(15, 60);
    endfunction

    // ---------------- driver ----------------
    int   send_gap  = 0;
    logic send_rush = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            s_valid       <= 1'b0;
            s_stream_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) advance_parser(s_stream_byte);
            if ($urandom_range(0, 199) == 0) send_rush = !send_rush;
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (track_bytes.size() > 0) begin
                    s_valid       <= 1'b1;
                    s_stream_byte <= track_bytes.pop_front();
                    send_gap = (!send_rush && $urandom_range(0, 99) < 35) ? idle_len() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int   stall_left = 0;
    logic recv_rush  = 1'b0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [27:0] got,
                               input logic [27:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      got_count, name, got, want));
    endtask

    task automatic check_result();
        result_t want;
        got_count++;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", got_count));
            return;
        end
        want = awaited_results.pop_front();
        check_field("result_kind",    28'(m_result_kind),   28'(want.result_kind));
        check_field("event_ticks",    m_event_ticks,        want.event_ticks);
        check_field("event_code",     28'(m_event_code),    28'(want.event_code));
        check_field("channel",        28'(m_channel),       28'(want.channel));
        check_field("param_first",    28'(m_param_first),   28'(want.param_first));
        check_field("param_second",   28'(m_param_second),  28'(want.param_second));
        check_field("meta_type",      28'(m_meta_type),     28'(want.meta_type));
        check_field("payload_length", m_payload_length,     want.payload_length);
        check_field("payload_byte",   28'(m_payload_byte),  28'(want.payload_byte));
        check_field("last_of_event",  28'(m_last_of_event), 28'(want.last_of_event));
        check_field("end_of_track",   28'(m_end_of_track),  28'(want.end_of_track));
        check_field("error_code",     28'(m_error_code),    28'(want.error_code));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
                // long hold so the input side backs up
                if (got_count % 300 == 50) stall_left = $urandom_range(200, 400);
            end
            if ($urandom_range(0, 199) == 0) recv_rush = !recv_rush;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!recv_rush && $urandom_range(0, 99) < 30) begin
                stall_left = idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[midi_track_event_parser] ERROR");
        $finish;
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int opening_len;
        int r;
        // max delta, note-on ch15; running two-param; program ch15 with bit 7 param;
        // four-byte zero delta, escape sysex with padded length; running sysex of
        // length zero; end of track
        track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, ST_NOTE_ON | 8'h0F, 8'h00, 8'hFF,
                        8'h00, 8'h7F, 8'h80,
                        8'h00, ST_PROGRAM | 8'h0F, 8'h80,
                        8'h80, 8'h80, 8'h80, 8'h00, ST_SYSEX_ESC, 8'h80, 8'h01, 8'hC3,
                        8'h00, 8'h00,
                        8'h00, ST_META, META_EOT, 8'h00};
        opening_len = track_bytes.size();
        gen_run = 8'h00;
        while (track_bytes.size() < opening_len + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 62)      gen_channel_event();
            else if (r < 78) gen_meta_event(1'b0);
            else if (r < 94) gen_sysex_event();
            else             gen_meta_event(1'b1);
        end
        append_halting_error();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (track_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[midi_track_event_parser] OK");
        end else begin
            $display("[midi_track_event_parser] ERROR");
        end
        $finish;
    end

endmodule

### files.f
src/mtep_pkg.sv
src/midi_track_event_parser.sv
tb/sv/tb_midi_track_event_parser.sv
